>>> hdl/tfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

    localparam int LANES = 8;

    // 3-bit source select per lane, lane 0 in the low bits
    localparam logic [23:0] DEF_LANE_SOURCE_MAP = 24'd16434824;
    localparam logic [7:0]  DEF_REVERSED_LANES  = 8'd0;

    // round(2^32 / 9.80665): newtons Q7.8 to kilograms Q16.16 after >> 24
    localparam logic signed [29:0] KG_RECIP = 30'sd437964779;

    localparam logic signed [15:0] ZERO_FORCE_PWM = 16'sd1500;
    localparam logic signed [15:0] PWM_MAX        = 16'sh7FFF;
    localparam logic signed [15:0] PWM_MIN        = 16'sh8000;

    localparam logic [63:0] LIMIT_RESET = 64'h05DC05DC05DC05DC;

    typedef enum logic [2:0] {
        REG_NEG_CUBIC_QUAD  = 3'd0,
        REG_NEG_LIN_CONST   = 3'd1,
        REG_POS_CUBIC_QUAD  = 3'd2,
        REG_POS_LIN_CONST   = 3'd3,
        REG_FLOOR_LOW       = 3'd4,
        REG_FLOOR_HIGH      = 3'd5,
        REG_CEILING_LOW     = 3'd6,
        REG_CEILING_HIGH    = 3'd7
    } t_reg_idx;

    typedef logic signed [15:0] t_pwm;

    // Q16.16 polynomial coefficients of one side
    typedef struct packed {
        logic signed [31:0] c3;
        logic signed [31:0] c2;
        logic signed [31:0] c1;
        logic signed [31:0] c0;
    } t_coef;

    typedef struct packed {
        t_coef neg;
        t_coef pos;
    } t_coef_pair;

    typedef struct packed {
        logic signed [15:0] force_0;
        logic signed [15:0] force_1;
        logic signed [15:0] force_2;
        logic signed [15:0] force_3;
        logic signed [15:0] force_4;
        logic signed [15:0] force_5;
        logic signed [15:0] force_6;
        logic signed [15:0] force_7;
    } t_force_word;

    typedef struct packed {
        logic signed [15:0] pwm_0;
        logic signed [15:0] pwm_1;
        logic signed [15:0] pwm_2;
        logic signed [15:0] pwm_3;
        logic signed [15:0] pwm_4;
        logic signed [15:0] pwm_5;
        logic signed [15:0] pwm_6;
        logic signed [15:0] pwm_7;
    } t_pwm_word;

endpackage

`default_nettype wire

>>> hdl/tfp_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module tfp_lane (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire logic signed [16:0]     i_force,
    input  wire tfp_pkg::t_coef_pair    i_coef,
    output tfp_pkg::t_pwm               o_pwm
);
    import tfp_pkg::*;

    logic signed [46:0] r1_prod;
    logic               r1_neg, r1_zero;

    logic signed [20:0] w_x;
    logic signed [20:0] r2_x;
    logic signed [41:0] r2_xx;
    logic               r2_neg, r2_zero;

    logic signed [24:0] w_x2;
    logic signed [31:0] w_c2, w_c1;
    logic signed [45:0] r3_x3p;
    logic signed [56:0] r3_p2;
    logic signed [52:0] r3_p1;
    logic               r3_neg, r3_zero;

    logic signed [28:0] w_x3;
    logic signed [31:0] w_c3, w_c0;
    logic signed [63:0] w_c0_sh;
    logic signed [60:0] r4_p3;
    logic signed [63:0] r4_p10;
    logic               r4_zero;

    logic signed [63:0] r5_sum;
    logic               r5_zero;

    logic signed [31:0] w_hi;
    logic               w_rnd;
    logic signed [31:0] w_q;
    t_pwm               n_pwm;
    t_pwm               r6_pwm;

    // |x| < 2^20, |x2| < 2^24, |x3| < 2^28: the floor shifts are plain part-selects
    assign w_x  = r1_prod[44:24];
    assign w_x2 = r2_xx[40:16];
    assign w_x3 = r3_x3p[44:16];

    assign w_c2 = r2_neg ? i_coef.neg.c2 : i_coef.pos.c2;
    assign w_c1 = r2_neg ? i_coef.neg.c1 : i_coef.pos.c1;
    assign w_c3 = r3_neg ? i_coef.neg.c3 : i_coef.pos.c3;
    assign w_c0 = r3_neg ? i_coef.neg.c0 : i_coef.pos.c0;
    assign w_c0_sh = {{16{w_c0[31]}}, w_c0, 16'b0};

    // truncate toward zero: floor of a negative sum with a nonzero fraction plus one
    assign w_hi  = r5_sum[63:32];
    assign w_rnd = r5_sum[63] && (r5_sum[31:0] != 32'd0);
    assign w_q   = w_hi + {31'd0, w_rnd};

    always_comb begin
        if (r5_zero) begin
            n_pwm = ZERO_FORCE_PWM;
        end else if (w_q > 32'sd32767) begin
            n_pwm = PWM_MAX;
        end else if (w_q < -32'sd32768) begin
            n_pwm = PWM_MIN;
        end else begin
            n_pwm = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= 47'(i_force) * 47'(KG_RECIP);
            r1_neg  <= i_force[16];
            r1_zero <= (i_force == 17'sd0);

            r2_x    <= w_x;
            r2_xx   <= 42'(w_x) * 42'(w_x);
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;

            r3_x3p  <= 46'(w_x2) * 46'(r2_x);
            r3_p2   <= 57'(w_c2) * 57'(w_x2);
            r3_p1   <= 53'(w_c1) * 53'(r2_x);
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;

            r4_p3   <= 61'(w_c3) * 61'(w_x3);
            r4_p10  <= 64'(r3_p2) + 64'(r3_p1) + w_c0_sh;
            r4_zero <= r3_zero;

            r5_sum  <= 64'(r4_p3) + r4_p10;
            r5_zero <= r4_zero;

            r6_pwm  <= n_pwm;
        end
    end

    assign o_pwm = r6_pwm;

endmodule

`default_nettype wire

>>> hdl/tfp_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module tfp_merge (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire tfp_pkg::t_pwm   i_pwm   [tfp_pkg::LANES],
    input  wire tfp_pkg::t_pwm   i_floor [tfp_pkg::LANES],
    input  wire tfp_pkg::t_pwm   i_ceil  [tfp_pkg::LANES],
    output logic                 o_valid,
    output tfp_pkg::t_pwm_word   o_word
);
    import tfp_pkg::*;

    t_pwm      w_clamp [LANES];
    t_pwm_word n_word;
    t_pwm_word r_word;
    logic      r_valid;

    // floor is checked first: when the limits cross, a word below the floor gets the floor, any other the ceiling
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (i_pwm[i] < i_floor[i]) begin
                w_clamp[i] = i_floor[i];
            end else if (i_pwm[i] > i_ceil[i]) begin
                w_clamp[i] = i_ceil[i];
            end else begin
                w_clamp[i] = i_pwm[i];
            end
        end
    end

    always_comb begin
        n_word.pwm_0 = w_clamp[0];
        n_word.pwm_1 = w_clamp[1];
        n_word.pwm_2 = w_clamp[2];
        n_word.pwm_3 = w_clamp[3];
        n_word.pwm_4 = w_clamp[4];
        n_word.pwm_5 = w_clamp[5];
        n_word.pwm_6 = w_clamp[6];
        n_word.pwm_7 = w_clamp[7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

>>> hdl/thruster_force_to_pwm_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction   handshake                 payload
// in        input       i_valid / o_stall         i_data  (t_force_word)
// out       output      o_valid / i_stall         o_data  (t_pwm_word)
// config    input       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; an accepted word
// reaches o_data through six lane stages (four dependent multiplies, the last
// beside a partial sum, a final add, rounding) plus the clamp register of the
// merge stage. Synchronous active-low reset clears the stage valids and loads
// the register reset values. An output stall freezes the whole pipeline and
// shows on o_stall in the same cycle.

module thruster_force_to_pwm_top #(
    parameter logic [23:0] LANE_SOURCE_MAP = tfp_pkg::DEF_LANE_SOURCE_MAP,
    parameter logic [7:0]  REVERSED_LANES  = tfp_pkg::DEF_REVERSED_LANES
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire tfp_pkg::t_force_word    i_data,
    output logic                         o_valid,
    input  wire                          i_stall,
    output tfp_pkg::t_pwm_word           o_data,
    input  wire                          i_cfg_we,
    input  wire [2:0]                    i_cfg_idx,
    input  wire [63:0]                   i_cfg_data
);
    import tfp_pkg::*;

    localparam int STAGES = 6;

    logic [63:0] r_neg_cq, r_neg_lc, r_pos_cq, r_pos_lc;
    logic [63:0] r_floor_lo, r_floor_hi, r_ceil_lo, r_ceil_hi;

    logic [STAGES-1:0] r_vld;
    logic              w_en;

    logic signed [15:0] w_src   [LANES];
    logic signed [16:0] w_force [LANES];
    t_pwm               w_pwm   [LANES];
    t_pwm               w_floor [LANES];
    t_pwm               w_ceil  [LANES];
    logic [127:0]       w_floor_all, w_ceil_all;
    t_coef_pair         w_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_cq   <= 64'd0;
            r_neg_lc   <= 64'd0;
            r_pos_cq   <= 64'd0;
            r_pos_lc   <= 64'd0;
            r_floor_lo <= LIMIT_RESET;
            r_floor_hi <= LIMIT_RESET;
            r_ceil_lo  <= LIMIT_RESET;
            r_ceil_hi  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_NEG_CUBIC_QUAD: r_neg_cq   <= i_cfg_data;
                REG_NEG_LIN_CONST:  r_neg_lc   <= i_cfg_data;
                REG_POS_CUBIC_QUAD: r_pos_cq   <= i_cfg_data;
                REG_POS_LIN_CONST:  r_pos_lc   <= i_cfg_data;
                REG_FLOOR_LOW:      r_floor_lo <= i_cfg_data;
                REG_FLOOR_HIGH:     r_floor_hi <= i_cfg_data;
                REG_CEILING_LOW:    r_ceil_lo  <= i_cfg_data;
                REG_CEILING_HIGH:   r_ceil_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_coef.neg.c3 = r_neg_cq[63:32];
    assign w_coef.neg.c2 = r_neg_cq[31:0];
    assign w_coef.neg.c1 = r_neg_lc[63:32];
    assign w_coef.neg.c0 = r_neg_lc[31:0];
    assign w_coef.pos.c3 = r_pos_cq[63:32];
    assign w_coef.pos.c2 = r_pos_cq[31:0];
    assign w_coef.pos.c1 = r_pos_lc[63:32];
    assign w_coef.pos.c0 = r_pos_lc[31:0];

    assign w_floor_all = {r_floor_hi, r_floor_lo};
    assign w_ceil_all  = {r_ceil_hi, r_ceil_lo};

    // whole pipeline holds while the output word waits
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    assign w_src[0] = i_data.force_0;
    assign w_src[1] = i_data.force_1;
    assign w_src[2] = i_data.force_2;
    assign w_src[3] = i_data.force_3;
    assign w_src[4] = i_data.force_4;
    assign w_src[5] = i_data.force_5;
    assign w_src[6] = i_data.force_6;
    assign w_src[7] = i_data.force_7;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        // -(-32768) stays exact in 17 bits
        assign w_force[g] = REVERSED_LANES[g] ? -17'(w_src[LANE_SOURCE_MAP[3*g +: 3]])
                                               :  17'(w_src[LANE_SOURCE_MAP[3*g +: 3]]);
        assign w_floor[g] = w_floor_all[16*g +: 16];
        assign w_ceil[g]  = w_ceil_all[16*g +: 16];

        tfp_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_force (w_force[g]),
            .i_coef  (w_coef),
            .o_pwm   (w_pwm[g])
        );
    end

    tfp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld[STAGES-1]),
        .i_pwm   (w_pwm),
        .i_floor (w_floor),
        .i_ceil  (w_ceil),
        .o_valid (o_valid),
        .o_word  (o_data)
    );

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no output word");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word missing from first stage");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_valid && i_stall) |=> ($stable(r_vld) && o_valid))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire
